FILE: rtl/srtf_pkg.sv
// ----------------------------------------------------------------------------
// srtf_pkg
// Shared widths and sequencer states for the SRTF scheduler simulator.
// ----------------------------------------------------------------------------
package srtf_pkg;

  localparam int ARR_W  = 12;
  localparam int BUR_W  = 12;
  localparam int IDX_W  = 4;
  localparam int TICK_W = 17;
  localparam int TOT_W  = 21;

  typedef enum logic [7:0] {
    S_LOAD   = 8'b0000_0001,
    S_SCAN   = 8'b0000_0010,
    S_DECIDE = 8'b0000_0100,
    S_FETCH  = 8'b0000_1000,
    S_EMIT   = 8'b0001_0000,
    S_DIVGO  = 8'b0010_0000,
    S_DIVW   = 8'b0100_0000,
    S_DIVT   = 8'b1000_0000
  } state_t;

endpackage

FILE: rtl/srtf_divider.sv
// ----------------------------------------------------------------------------
// srtf_divider
// Restoring divider, one quotient bit per cycle; done pulses when finished.
// ----------------------------------------------------------------------------
module srtf_divider #(
  parameter int DW = 5
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [srtf_pkg::TOT_W-1:0] dividend,
  input  logic [DW-1:0]             divisor,
  output logic                      done,
  output logic [srtf_pkg::TOT_W-1:0] quotient
);

  localparam int NCW = $clog2(srtf_pkg::TOT_W + 1);

  logic                       busy;
  logic [NCW-1:0]             cnt;
  logic [DW-1:0]              rem;
  logic [DW-1:0]              dvs;
  logic [srtf_pkg::TOT_W-1:0] quo;
  logic [DW:0]                rem_sh;
  logic [DW:0]                diff;
  logic                       ge;

  always_comb begin
    rem_sh = {rem, quo[srtf_pkg::TOT_W-1]};
    diff   = rem_sh - {1'b0, dvs};
    ge     = rem_sh >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= NCW'(srtf_pkg::TOT_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == NCW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= ge ? diff[DW-1:0] : rem_sh[DW-1:0];
      quo <= {quo[srtf_pkg::TOT_W-2:0], ge};
    end
  end

  assign quotient = quo;

endmodule

FILE: rtl/srtf_scheduler_sim.sv
// ----------------------------------------------------------------------------
// srtf_scheduler_sim
// Preemptive shortest-remaining-time-first scheduler simulator.
// Loads are taken while the block sits in its load state. After the final job, each
// simulated tick reads the store once per job through a shared compare unit and then
// decides; a finishing record adds a fetch and an emit state, and the summary waits on
// two divides. Synchronous reset clears the set, counts, clock and totals.
// ----------------------------------------------------------------------------
module srtf_scheduler_sim #(
  parameter int MAX_PROCS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        job_valid,
  output logic        job_stall,
  input  logic [11:0] arrival,
  input  logic [11:0] burst,
  input  logic        final_job,
  output logic        record_valid,
  input  logic        record_stall,
  output logic [3:0]  job_index,
  output logic [16:0] start_tick,
  output logic [16:0] finish_tick,
  output logic [16:0] wait_span,
  output logic [16:0] turnaround_span,
  output logic        is_summary,
  output logic [16:0] mean_wait,
  output logic [16:0] mean_turnaround,
  output logic        run_done
);

  localparam int IW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CW = $clog2(MAX_PROCS + 1);
  localparam int TW = srtf_pkg::ARR_W + CW;

  srtf_pkg::state_t state, state_next;

  logic [srtf_pkg::ARR_W-1:0]  arr_mem   [MAX_PROCS];
  logic [srtf_pkg::BUR_W-1:0]  rem_mem   [MAX_PROCS];
  logic [srtf_pkg::TICK_W-1:0] start_mem [MAX_PROCS];

  logic [CW-1:0]              job_count;
  logic [CW-1:0]              finished;
  logic [TW-1:0]              t;
  logic [srtf_pkg::TOT_W-1:0] wait_total;
  logic [srtf_pkg::TOT_W-1:0] turn_total;
  logic [MAX_PROCS-1:0]       started;

  logic [CW-1:0]               scan_idx;
  logic                        rd_vld;
  logic [IW-1:0]               rd_idx;
  logic [srtf_pkg::ARR_W-1:0]  arr_q;
  logic [srtf_pkg::BUR_W-1:0]  rem_q;
  logic [srtf_pkg::TICK_W-1:0] start_q;

  logic                       best_found;
  logic [IW-1:0]              best_idx;
  logic [srtf_pkg::ARR_W-1:0] best_arr;
  logic [srtf_pkg::BUR_W-1:0] best_rem;
  logic [srtf_pkg::ARR_W-1:0] next_min;
  logic [srtf_pkg::TICK_W-1:0] mean_w;

  logic                       load_store;
  logic [srtf_pkg::BUR_W-1:0] bur_fix;
  logic                       decide_run;
  logic                       rem_we;
  logic [IW-1:0]              rem_wa;
  logic [srtf_pkg::BUR_W-1:0] rem_wd;
  logic                       start_we;
  logic                       take;
  logic                       pend;
  logic                       out_free;
  logic                       scan_init;
  logic                       emit_job;
  logic                       emit_sum;
  logic                       div_start;
  logic                       div_done;
  logic                       div_ready;
  logic [srtf_pkg::TOT_W-1:0] div_q;
  logic [srtf_pkg::TOT_W-1:0] div_a;
  logic [TW-1:0]              span_t;

  assign job_stall  = (state != srtf_pkg::S_LOAD);
  assign load_store = job_valid && (state == srtf_pkg::S_LOAD) &&
                      (job_count < CW'(MAX_PROCS));
  assign bur_fix    = (burst == '0) ? srtf_pkg::BUR_W'(1) : burst;
  assign decide_run = (state == srtf_pkg::S_DECIDE) && best_found;
  assign rem_we     = load_store || decide_run;
  assign rem_wa     = load_store ? job_count[IW-1:0] : best_idx;
  assign rem_wd     = load_store ? bur_fix : best_rem - 1'b1;
  assign start_we   = decide_run && !started[best_idx];
  assign out_free   = !record_valid || !record_stall;
  assign span_t     = t - TW'(best_arr);
  assign div_a      = (state == srtf_pkg::S_DIVGO) ? wait_total : turn_total;

  // shared compare unit: one job per cycle
  always_comb begin
    take = rd_vld && (rem_q != '0) && (TW'(arr_q) <= t) &&
           (!best_found || (rem_q < best_rem) ||
            ((rem_q == best_rem) && (arr_q < best_arr)));
    pend = rd_vld && (rem_q != '0) && (arr_q < next_min);
  end

  always_comb begin
    state_next = state;
    scan_init  = 1'b0;
    emit_job   = 1'b0;
    emit_sum   = 1'b0;
    div_start  = 1'b0;
    unique case (state)
      srtf_pkg::S_LOAD: begin
        if (job_valid && final_job) begin
          state_next = srtf_pkg::S_SCAN;
          scan_init  = 1'b1;
        end
      end
      srtf_pkg::S_SCAN: begin
        if (scan_idx == job_count) state_next = srtf_pkg::S_DECIDE;
      end
      srtf_pkg::S_DECIDE: begin
        if (best_found && (best_rem == srtf_pkg::BUR_W'(1))) begin
          state_next = srtf_pkg::S_FETCH;
        end else begin
          state_next = srtf_pkg::S_SCAN;
          scan_init  = 1'b1;
        end
      end
      srtf_pkg::S_FETCH: begin
        state_next = srtf_pkg::S_EMIT;
      end
      srtf_pkg::S_EMIT: begin
        if (out_free) begin
          emit_job = 1'b1;
          if (CW'(finished + 1'b1) == job_count) begin
            state_next = srtf_pkg::S_DIVGO;
          end else begin
            state_next = srtf_pkg::S_SCAN;
            scan_init  = 1'b1;
          end
        end
      end
      srtf_pkg::S_DIVGO: begin
        div_start  = 1'b1;
        state_next = srtf_pkg::S_DIVW;
      end
      srtf_pkg::S_DIVW: begin
        if (div_done) begin
          div_start  = 1'b1;
          state_next = srtf_pkg::S_DIVT;
        end
      end
      srtf_pkg::S_DIVT: begin
        if ((div_done || div_ready) && out_free) begin
          emit_sum   = 1'b1;
          state_next = srtf_pkg::S_LOAD;
        end
      end
      default: state_next = srtf_pkg::S_LOAD;
    endcase
  end

  // divide result stays valid after done; summary waits in S_DIVT on done or the held ready flag and a free output
  always_ff @(posedge clk) begin
    if (rst) begin
      div_ready <= 1'b0;
    end else if (div_start) begin
      div_ready <= 1'b0;
    end else if (div_done) begin
      div_ready <= 1'b1;
    end
  end

  srtf_divider #(
    .DW(CW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (job_count),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (load_store) arr_mem[job_count[IW-1:0]] <= arrival;
    if (rem_we) rem_mem[rem_wa] <= rem_wd;
    if (start_we) start_mem[best_idx] <= srtf_pkg::TICK_W'(t);
    arr_q   <= arr_mem[scan_idx[IW-1:0]];
    rem_q   <= rem_mem[scan_idx[IW-1:0]];
    start_q <= start_mem[best_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= srtf_pkg::S_LOAD;
      job_count    <= '0;
      finished     <= '0;
      t            <= '0;
      wait_total   <= '0;
      turn_total   <= '0;
      started      <= '0;
      scan_idx     <= '0;
      rd_vld       <= 1'b0;
      best_found   <= 1'b0;
      record_valid <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= (state == srtf_pkg::S_SCAN) && (scan_idx != job_count);
      if (load_store) begin
        job_count                   <= job_count + 1'b1;
        started[job_count[IW-1:0]] <= 1'b0;
      end
      if (scan_init) begin
        scan_idx   <= '0;
        best_found <= 1'b0;
      end else begin
        if ((state == srtf_pkg::S_SCAN) && (scan_idx != job_count)) begin
          scan_idx <= scan_idx + 1'b1;
        end
        if (take) best_found <= 1'b1;
      end
      if (state == srtf_pkg::S_DECIDE) begin
        if (!best_found) begin
          t <= TW'(next_min);
        end else begin
          t <= t + 1'b1;
          if (!started[best_idx]) begin
            started[best_idx] <= 1'b1;
            wait_total <= wait_total + srtf_pkg::TOT_W'(span_t);
          end
        end
      end
      if (emit_job) begin
        finished   <= finished + 1'b1;
        turn_total <= turn_total + srtf_pkg::TOT_W'(span_t);
      end
      if (emit_sum) begin
        job_count  <= '0;
        finished   <= '0;
        t          <= '0;
        wait_total <= '0;
        turn_total <= '0;
        started    <= '0;
      end
      if (emit_job || emit_sum) begin
        record_valid <= 1'b1;
      end else if (!record_stall) begin
        record_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= scan_idx[IW-1:0];
    if (scan_init) begin
      next_min <= '1;
    end else if (pend) begin
      next_min <= arr_q;
    end
    if (take) begin
      best_idx <= rd_idx;
      best_arr <= arr_q;
      best_rem <= rem_q;
    end
    if ((state == srtf_pkg::S_DIVW) && div_done) begin
      mean_w <= srtf_pkg::TICK_W'(div_q);
    end
    if (emit_job) begin
      job_index       <= srtf_pkg::IDX_W'(best_idx);
      start_tick      <= start_q;
      finish_tick     <= srtf_pkg::TICK_W'(t);
      wait_span       <= start_q - srtf_pkg::TICK_W'(best_arr);
      turnaround_span <= srtf_pkg::TICK_W'(span_t);
      is_summary      <= 1'b0;
      mean_wait       <= '0;
      mean_turnaround <= '0;
      run_done        <= 1'b0;
    end else if (emit_sum) begin
      job_index       <= '0;
      start_tick      <= '0;
      finish_tick     <= '0;
      wait_span       <= '0;
      turnaround_span <= '0;
      is_summary      <= 1'b1;
      mean_wait       <= mean_w;
      mean_turnaround <= srtf_pkg::TICK_W'(div_q);
      run_done        <= 1'b1;
    end
  end

endmodule

FILE: tb/tb_srtf_scheduler_sim.sv
// ----------------------------------------------------------------------------
// tb_srtf_scheduler_sim
// Self-checking bench for the preemptive SRTF scheduler simulator. Job sets are
// loaded over the request channel. Every record that comes back is compared
// field by field with an in-bench schedule predictor or, for typed directed rows,
// with the ticks in the table. The run has directed corner sets, then random sets
// under several sender/receiver idle mixes, and then a long receiver hold-off that backs the block up into its input.
// ----------------------------------------------------------------------------
module tb_srtf_scheduler_sim;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          JOB_SLOTS    = 16;
  localparam int unsigned TOT_MASK     = (1 << srtf_pkg::TOT_W) - 1;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          DRAIN_CYCLES = 64;
  localparam int          CYCLE_LIMIT  = 4_000_000;

  typedef struct packed {
    logic [srtf_pkg::IDX_W-1:0]  idx;
    logic [srtf_pkg::TICK_W-1:0] start;
    logic [srtf_pkg::TICK_W-1:0] finish;
    logic [srtf_pkg::TICK_W-1:0] waited;
    logic [srtf_pkg::TICK_W-1:0] turn;
    logic                        summ;
    logic [srtf_pkg::TICK_W-1:0] avg_wait;
    logic [srtf_pkg::TICK_W-1:0] avg_turn;
    logic                        last_rec;
  } sched_rec_t;

  typedef struct packed {
    logic [srtf_pkg::ARR_W-1:0]  arr;
    logic [srtf_pkg::BUR_W-1:0]  bur;
    logic                        last_job;
    logic                        typed;
    logic [srtf_pkg::TICK_W-1:0] t_start;
    logic [srtf_pkg::TICK_W-1:0] t_finish;
  } job_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              job_valid = 1'b0;
  logic              job_stall;
  logic [11:0]       arrival = '0;
  logic [11:0]       burst = '0;
  logic              final_job = 1'b0;
  logic              record_valid;
  logic              record_stall = 1'b0;
  logic [3:0]        job_index;
  logic [16:0]       start_tick;
  logic [16:0]       finish_tick;
  logic [16:0]       wait_span;
  logic [16:0]       turnaround_span;
  logic              is_summary;
  logic [16:0]       mean_wait;
  logic [16:0]       mean_turnaround;
  logic              run_done;

  srtf_scheduler_sim #(.MAX_PROCS(JOB_SLOTS)) u_dut (
    .clk             (clk),
    .rst             (rst),
    .job_valid       (job_valid),
    .job_stall       (job_stall),
    .arrival         (arrival),
    .burst           (burst),
    .final_job       (final_job),
    .record_valid    (record_valid),
    .record_stall    (record_stall),
    .job_index       (job_index),
    .start_tick      (start_tick),
    .finish_tick     (finish_tick),
    .wait_span       (wait_span),
    .turnaround_span (turnaround_span),
    .is_summary      (is_summary),
    .mean_wait       (mean_wait),
    .mean_turnaround (mean_turnaround),
    .run_done        (run_done)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // schedule predictor state
  logic [srtf_pkg::ARR_W-1:0]  slot_arrival [JOB_SLOTS];
  logic [srtf_pkg::BUR_W-1:0]  slot_left    [JOB_SLOTS];
  logic [srtf_pkg::TICK_W-1:0] slot_start   [JOB_SLOTS];
  bit                          slot_begun   [JOB_SLOTS];
  int unsigned       jobs_held = 0;
  int unsigned       wait_sum = 0;
  int unsigned       turn_sum = 0;

  sched_rec_t  run_records [$];
  sched_rec_t  due_records [$];
  int          mismatch_count = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          set_serial = 0;
  int          cycle_count = 0;
  bit          hold_req = 1'b0;
  bit          hold_active = 1'b0;

  job_row_t directed_rows [10] = '{
    '{12'd0,    12'd1,    1'b1, 1'b1, 17'd0,    17'd1},
    '{12'd4095, 12'd4095, 1'b1, 1'b1, 17'd4095, 17'd8190},
    '{12'd7,    12'd0,    1'b1, 1'b1, 17'd7,    17'd8},    // zero burst runs one tick
    '{12'd0,    12'd8,    1'b0, 1'b0, 17'd0,    17'd0},
    '{12'd1,    12'd4,    1'b0, 1'b0, 17'd0,    17'd0},
    '{12'd2,    12'd2,    1'b0, 1'b0, 17'd0,    17'd0},
    '{12'd3,    12'd4,    1'b0, 1'b0, 17'd0,    17'd0},
    '{12'd3,    12'd4,    1'b0, 1'b0, 17'd0,    17'd0},    // full tie: lower index wins
    '{12'd60,   12'd3,    1'b0, 1'b0, 17'd0,    17'd0},    // idle gap before this one
    '{12'd0,    12'd1,    1'b1, 1'b0, 17'd0,    17'd0}
  };

  function automatic sched_rec_t make_rec(input int unsigned idx, input int unsigned st,
                                          input int unsigned fin, input int unsigned wt,
                                          input int unsigned tat, input bit summ,
                                          input int unsigned mw, input int unsigned mt);
    sched_rec_t r;
    r.idx      = idx[srtf_pkg::IDX_W-1:0];
    r.start    = st[srtf_pkg::TICK_W-1:0];
    r.finish   = fin[srtf_pkg::TICK_W-1:0];
    r.waited   = wt[srtf_pkg::TICK_W-1:0];
    r.turn     = tat[srtf_pkg::TICK_W-1:0];
    r.summ     = summ;
    r.avg_wait = mw[srtf_pkg::TICK_W-1:0];
    r.avg_turn = mt[srtf_pkg::TICK_W-1:0];
    r.last_rec = summ;
    return r;
  endfunction

  function automatic void schedule_job(input logic [srtf_pkg::ARR_W-1:0] arr,
                                       input logic [srtf_pkg::BUR_W-1:0] bur,
                                       input bit last_job);
    int unsigned t, nxt, fin, turn, n, finished;
    int          pick, i;
    run_records.delete();
    if (bur == '0) bur = srtf_pkg::BUR_W'(1);
    if (jobs_held < JOB_SLOTS) begin
      slot_arrival[jobs_held] = arr;
      slot_left[jobs_held]    = bur;
      slot_begun[jobs_held]   = 1'b0;
      jobs_held++;
    end
    if (!last_job) return;
    n = jobs_held;
    t = 0;
    finished = 0;
    while (finished < n) begin
      pick = -1;
      for (i = 0; i < n; i++) begin
        if (slot_left[i] == 0 || slot_arrival[i] > t) continue;
        if (pick < 0 || slot_left[i] < slot_left[pick] ||
            (slot_left[i] == slot_left[pick] && slot_arrival[i] < slot_arrival[pick]))
          pick = i;
      end
      if (pick < 0) begin
        nxt = '1;
        for (i = 0; i < n; i++)
          if (slot_left[i] != 0 && slot_arrival[i] < nxt) nxt = 32'(slot_arrival[i]);
        t = nxt;
        continue;
      end
      if (!slot_begun[pick]) begin
        slot_begun[pick] = 1'b1;
        slot_start[pick] = t[srtf_pkg::TICK_W-1:0];
        wait_sum = (wait_sum + t - slot_arrival[pick]) & TOT_MASK;
      end
      slot_left[pick]--;
      if (slot_left[pick] == 0) begin
        fin = t + 1;
        turn = fin - slot_arrival[pick];
        turn_sum = (turn_sum + turn) & TOT_MASK;
        finished++;
        run_records = {run_records,
                       make_rec(pick, 32'(slot_start[pick]), fin,
                                32'(slot_start[pick]) - 32'(slot_arrival[pick]), turn,
                                1'b0, 0, 0)};
      end
      t++;
    end
    run_records = {run_records,
                   make_rec(0, 0, 0, 0, 0, 1'b1,
                            n ? wait_sum / n : 0, n ? turn_sum / n : 0)};
    jobs_held = 0;
    wait_sum = 0;
    turn_sum = 0;
    for (i = 0; i < JOB_SLOTS; i++) slot_begun[i] = 1'b0;
  endfunction

  task automatic log_mismatch(input string msg);
    $display("[%0t] MISMATCH %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input int unsigned got,
                             input int unsigned want);
    if (got != want) log_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  // called at a falling edge, returns at a falling edge
  task automatic issue_job(input job_row_t row);
    while ($urandom_range(0, 99) < idle_pct) begin
      job_valid <= 1'b0;
      @(negedge clk);
    end
    job_valid <= 1'b1;
    arrival   <= row.arr;
    burst     <= row.bur;
    final_job <= row.last_job;
    @(posedge clk);
    while (job_stall) @(posedge clk);
    schedule_job(row.arr, row.bur, row.last_job);
    if (row.typed) begin
      due_records = {due_records,
                     make_rec(0, 32'(row.t_start), 32'(row.t_finish),
                              32'(row.t_start) - 32'(row.arr),
                              32'(row.t_finish) - 32'(row.arr), 1'b0, 0, 0)};
      due_records = {due_records,
                     make_rec(0, 0, 0, 0, 0, 1'b1, 0,
                              32'(row.t_finish) - 32'(row.arr))};
    end else begin
      due_records = {due_records, run_records};
    end
    @(negedge clk);
  endtask

  task automatic random_sets(input int items, input int send_idle, input int recv_stall);
    int       sent, size, k;
    bit       wide;
    job_row_t row;
    idle_pct  = send_idle;
    stall_pct = recv_stall;
    sent = 0;
    while (sent < items) begin
      set_serial++;
      // wide sets reach the top bits but cost thousands of ticks, so keep them rare
      wide = (set_serial % 12 == 0);
      if (wide) size = $urandom_range(1, 2);
      else if ($urandom_range(0, 9) == 0) size = $urandom_range(12, 19);
      else size = $urandom_range(1, 7);
      for (k = 0; k < size; k++) begin
        row          = '0;
        row.arr      = wide ? srtf_pkg::ARR_W'($urandom_range(0, 4095)) :
                              srtf_pkg::ARR_W'($urandom_range(0, 40));
        row.bur      = wide ? srtf_pkg::BUR_W'($urandom_range(0, 4095)) :
                              srtf_pkg::BUR_W'($urandom_range(0, 15));
        row.last_job = (k == size - 1);
        issue_job(row);
      end
      sent += size;
    end
  endtask

  always @(negedge clk)
    record_stall <= hold_active || ($urandom_range(0, 99) < stall_pct);

  initial begin
    wait (hold_req);
    @(posedge clk);
    hold_active = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_active = 1'b0;
  end

  always @(posedge clk) begin
    sched_rec_t want;
    if (!rst && record_valid && !record_stall) begin
      if (due_records.size() == 0) begin
        log_mismatch($sformatf("record with nothing pending, job_index %0d summary %0d",
                               job_index, is_summary));
      end else begin
        want = due_records.pop_front();
        check_field("job_index", 32'(job_index), 32'(want.idx));
        check_field("start_tick", 32'(start_tick), 32'(want.start));
        check_field("finish_tick", 32'(finish_tick), 32'(want.finish));
        check_field("wait_span", 32'(wait_span), 32'(want.waited));
        check_field("turnaround_span", 32'(turnaround_span), 32'(want.turn));
        check_field("is_summary", 32'(is_summary), 32'(want.summ));
        check_field("mean_wait", 32'(mean_wait), 32'(want.avg_wait));
        check_field("mean_turnaround", 32'(mean_turnaround), 32'(want.avg_turn));
        check_field("run_done", 32'(run_done), 32'(want.last_rec));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[%0t] timeout, %0d records still pending", $realtime, due_records.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    job_row_t row;
    int       k, s;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[r]) issue_job(directed_rows[r]);
    // overfull set: the 17th request is dropped, the 18th is dropped but starts the run
    for (k = 0; k < 18; k++) begin
      row          = '0;
      row.arr      = srtf_pkg::ARR_W'(k % 6);
      row.bur      = srtf_pkg::BUR_W'(1 + (k * 5) % 9);
      row.last_job = (k == 17);
      issue_job(row);
    end

    random_sets(70, 0, 0);
    random_sets(70, 77, 0);
    random_sets(70, 0, 77);
    random_sets(70, 16, 16);

    // back-pressure: receiver holds off while short sets keep coming
    idle_pct  = 0;
    stall_pct = 0;
    hold_req  = 1'b1;
    for (s = 0; s < 3; s++) begin
      for (k = 0; k < 4; k++) begin
        row          = '0;
        row.arr      = srtf_pkg::ARR_W'($urandom_range(0, 3));
        row.bur      = srtf_pkg::BUR_W'($urandom_range(1, 3));
        row.last_job = (k == 3);
        issue_job(row);
      end
    end
    job_valid <= 1'b0;

    while (due_records.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
